@@ sv/cwrl_pkg.sv @@
// ----------------------------------------------------------------------------
// cwrl_pkg
// Types and constants shared by the restart limiter modules.
// ----------------------------------------------------------------------------
package cwrl_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_COMM      = 2'd1;
    localparam logic [1:0] CMD_CLR_TRIES = 2'd2;

    // indicator codes
    localparam logic [1:0] IND_STANDBY = 2'd0;
    localparam logic [1:0] IND_WARNING = 2'd1;
    localparam logic [1:0] IND_RESTART = 2'd2;
    localparam logic [1:0] IND_COMM_OK = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_EXPIRY_MS   = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] REG_WARNING_MS  = 2'd2;

    // configuration reset values
    localparam logic [31:0] EXPIRY_MS_RST   = 32'd600000;
    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd3;
    localparam logic [31:0] WARNING_MS_RST  = 32'd60000;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] tick_elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  indicator;
        logic        trigger;
        logic        is_halted;
        logic [7:0]  attempt_count;
        logic [31:0] remaining_ms;
    } out_item_t;

    typedef struct packed {
        logic [31:0] expiry_ms;
        logic [7:0]  retry_limit;
        logic [31:0] warning_ms;
    } cfg_t;

endpackage

@@ sv/cwrl_cfg.sv @@
// ----------------------------------------------------------------------------
// cwrl_cfg
// Configuration registers written through a plain write port.
// ----------------------------------------------------------------------------
module cwrl_cfg
    import cwrl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_EXPIRY_MS:   cfg_next.expiry_ms   = cfg_data;
                REG_RETRY_LIMIT: cfg_next.retry_limit = cfg_data[7:0];
                REG_WARNING_MS:  cfg_next.warning_ms  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expiry_ms   <= EXPIRY_MS_RST;
            cfg_reg.retry_limit <= RETRY_LIMIT_RST;
            cfg_reg.warning_ms  <= WARNING_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/cwrl_core.sv @@
// ----------------------------------------------------------------------------
// cwrl_core
// Watchdog state and the single-pass update for one item.
// ----------------------------------------------------------------------------
module cwrl_core
    import cwrl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t res
);

    logic [31:0] since_reg;
    logic [31:0] since_next;
    logic [7:0]  attempts_reg;
    logic [7:0]  attempts_next;
    logic        halted_reg;
    logic        halted_next;
    logic [1:0]  led_reg;
    logic [1:0]  led_next;

    logic [32:0] sum;
    logic [31:0] base_since;
    logic [32:0] diff;
    logic [31:0] left;
    logic        is_tick;
    logic        fired;

    assign is_tick = (item.command == CMD_TICK) && !halted_reg;
    assign sum     = {1'b0, since_reg} + {17'b0, item.tick_elapsed_ms};
    // saturating add
    assign base_since = !is_tick ? since_reg : (sum[32] ? '1 : sum[31:0]);
    assign diff       = {1'b0, cfg.expiry_ms} - {1'b0, base_since};
    assign left       = diff[32] ? '0 : diff[31:0];

    always_comb
    begin
        since_next    = since_reg;
        attempts_next = attempts_reg;
        halted_next   = halted_reg;
        led_next      = led_reg;
        fired         = 1'b0;
        case (item.command)
            CMD_TICK:
            begin
                if (is_tick)
                begin
                    since_next = base_since;
                    if (left != '0 && left <= cfg.warning_ms)
                    begin
                        if (led_reg == IND_STANDBY)
                            led_next = IND_WARNING;
                    end
                    else if (left > cfg.warning_ms)
                    begin
                        if (led_reg == IND_WARNING)
                            led_next = IND_STANDBY;
                    end
                    if (left == '0)
                    begin
                        if (attempts_reg >= cfg.retry_limit)
                        begin
                            led_next    = IND_STANDBY;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            attempts_next = attempts_reg + 8'd1;
                            led_next      = IND_RESTART;
                            fired         = 1'b1;
                            since_next    = '0;
                        end
                    end
                end
            end
            CMD_COMM:
            begin
                since_next    = '0;
                halted_next   = 1'b0;
                attempts_next = '0;
                led_next      = IND_COMM_OK;
            end
            CMD_CLR_TRIES:
            begin
                attempts_next = '0;
                halted_next   = 1'b0;
            end
            default:
            begin
                since_next = since_reg;
            end
        endcase
    end

    always_comb
    begin
        res.indicator     = led_next;
        res.trigger       = fired;
        res.is_halted     = halted_next;
        res.attempt_count = attempts_next;
        // counter restarts at zero after a restart or communication
        res.remaining_ms  = (fired || item.command == CMD_COMM) ? cfg.expiry_ms : left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg    <= '0;
            attempts_reg <= '0;
            halted_reg   <= 1'b0;
            led_reg      <= IND_STANDBY;
        end
        else if (en)
        begin
            since_reg    <= since_next;
            attempts_reg <= attempts_next;
            halted_reg   <= halted_next;
            led_reg      <= led_next;
        end
    end

    a_fire_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        en && fired |=> since_reg == '0 && attempts_reg == $past(attempts_reg) + 8'd1)
        else $error("restart did not clear counter or bump attempts");

    a_comm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        en && item.command == CMD_COMM |=>
            !halted_reg && attempts_reg == '0 && led_reg == IND_COMM_OK)
        else $error("communication did not clear state");

    a_halt_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        en && halted_reg && item.command == CMD_TICK |=>
            halted_reg && $stable(since_reg) && $stable(attempts_reg))
        else $error("tick changed state while halted");

    a_fire_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
        fired |-> !halted_next && !halted_reg)
        else $error("restart fired while halted");

endmodule

@@ sv/comm_watchdog_restart_limiter.sv @@
// ----------------------------------------------------------------------------
// comm_watchdog_restart_limiter
// Communication-loss watchdog with a limit on restart attempts.
// ----------------------------------------------------------------------------
// Usage: each input item is a check tick with elapsed milliseconds, a
// communication-received event or a clear-attempts command; every item gives
// exactly one result with the indicator, trigger pulse, halted flag, attempt
// count and remaining time. Both channels use valid/stall: an item moves on a
// rising edge where valid is high and stall is low.
// The item sits in the input register while the update logic runs, and the
// result register loads when the item advances. Throughput is one item per
// cycle while the receiver does not stall; the state update is a single add,
// subtract and compare loop. While the receiver stalls, the result register
// holds; one more item waits in the input register, after which the input
// side stalls. Reset clears the counter, attempts, halted flag and indicator
// (standby) and loads the configuration defaults. The user must write
// configuration through cfg_we/cfg_index/cfg_data only while no item is in
// flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module comm_watchdog_restart_limiter
    import cwrl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  in_item_t    item,
    output logic        result_valid,
    input  logic        result_stall,
    output out_item_t   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t      cfg;
    out_item_t core_res;

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      advance;

    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;

    cwrl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cwrl_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (in_data_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                in_valid_reg <= item_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_data_reg <= item;
        if (advance)
            out_data_reg <= core_res;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule
